@@ hw/rtl/aar_pkg.sv @@
// ----------------------------------------------------------------------------
// aar_pkg
// Types, widths and constants of the axis-angle to rotation matrix block.
// ----------------------------------------------------------------------------
package aar_pkg;

  localparam int IN_BITS       = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_BITS      = OUT_FRAC_BITS + 2;

  // Angle and CORDIC datapath, Q30 with headroom
  localparam int ZW = 34;
  localparam int CW = 34;
  // Quaternion components, Q24
  localparam int QW = 28;
  localparam int QUAT_DROP = 6;
  // Quadratic terms and sums
  localparam int PW = 2 * QW;
  localparam int SW = PW + 1;
  // Divider remainder, holds twice four times the norm
  localparam int RW = PW + 4;
  // Quotient bits: two integer bits and OUT_FRAC_BITS+1 fraction bits
  localparam int QB = OUT_FRAC_BITS + 3;
  localparam int EW = OUT_BITS + 3;

  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
  localparam logic signed [CW-1:0] CORDIC_X0   = CW'(1) << 30;
  localparam logic signed [OUT_BITS-1:0] ONE_OUT = OUT_BITS'(1) << OUT_FRAC_BITS;
  localparam logic signed [EW-1:0] ONE_EXT = EW'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic signed [IN_BITS-1:0] angle;
    logic signed [IN_BITS-1:0] axis_x;
    logic signed [IN_BITS-1:0] axis_y;
    logic signed [IN_BITS-1:0] axis_z;
  } aar_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] m00;
    logic signed [OUT_BITS-1:0] m01;
    logic signed [OUT_BITS-1:0] m02;
    logic signed [OUT_BITS-1:0] m10;
    logic signed [OUT_BITS-1:0] m11;
    logic signed [OUT_BITS-1:0] m12;
    logic signed [OUT_BITS-1:0] m20;
    logic signed [OUT_BITS-1:0] m21;
    logic signed [OUT_BITS-1:0] m22;
    logic                       degenerate;
  } aar_res_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:       v = ZW'(64'sd843314857);
      1:       v = ZW'(64'sd497837829);
      2:       v = ZW'(64'sd263043837);
      3:       v = ZW'(64'sd133525159);
      4:       v = ZW'(64'sd67021687);
      5:       v = ZW'(64'sd33543516);
      6:       v = ZW'(64'sd16775851);
      7:       v = ZW'(64'sd8388437);
      8:       v = ZW'(64'sd4194283);
      9:       v = ZW'(64'sd2097149);
      default: v = (i <= 30) ? (ZW'(1) << (30 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/axis_angle_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Angle and axis in, normalized quaternion rotation matrix out, pipelined.
// ----------------------------------------------------------------------------
// A request is taken in every cycle that start_i is high; busy_o stays low.
// Each request gives one result, marked by valid_o for one cycle, after
// one input register, one CORDIC stage per iteration, quaternion, product
// and sum stages, a restoring divider of 17 stages (one quotient bit each,
// nine lanes) and an output register. The receiver cannot stall, so
// results must be taken.
module axis_angle_to_rotation_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  aar_pkg::aar_req_t req_i,
  output logic              busy_o,
  output logic              valid_o,
  output aar_pkg::aar_res_t res_o
);
  import aar_pkg::*;

  localparam int CS  = CORDIC_STAGES;
  localparam int LAT = CS + QB + 5;

  logic [LAT-1:0] vld_q, vld_d;

  logic signed [ZW-1:0]      z_q  [CS+1];
  logic signed [CW-1:0]      cx_q [CS+1];
  logic signed [CW-1:0]      cy_q [CS+1];
  logic signed [IN_BITS-1:0] ax_q [CS+1];
  logic signed [IN_BITS-1:0] ay_q [CS+1];
  logic signed [IN_BITS-1:0] az_q [CS+1];

  logic signed [ZW-1:0] z_raw, z_fold;

  logic signed [IN_BITS+CW-1:0] px, py, pz;
  logic signed [QW-1:0] qx_q, qy_q, qz_q, qw_q;

  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;

  logic [PW-1:0]        n2;
  logic signed [SW-1:0] t [9];
  logic [SW-1:0]        mag [9];

  logic [RW-1:0] rem_q [QB+1][9];
  logic [QB-1:0] quo_q [QB+1][9];
  logic [RW-1:0] den_q [QB+1];
  logic [8:0]    neg_q [QB+1];
  logic          dg_q  [QB+1];

  logic [QB:0]          rnd [9];
  logic signed [EW-1:0] ent [9];
  logic signed [OUT_BITS-1:0] ent_sat [9];
  aar_res_t res_d, res_q;

  assign busy_o  = 1'b0;
  assign vld_d   = {vld_q[LAT-2:0], start_i};
  assign valid_o = vld_q[LAT-1];
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Half angle to Q30, folded into [-pi/2, pi/2]; the fold only negates q
  always_comb begin
    z_raw = ZW'(req_i.angle) <<< (33 - IN_BITS);
    if (z_raw > HALF_PI_Q30) begin
      z_fold = z_raw - PI_Q30;
    end else if (z_raw < -HALF_PI_Q30) begin
      z_fold = z_raw + PI_Q30;
    end else begin
      z_fold = z_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q[0]  <= z_fold;
    cx_q[0] <= CORDIC_X0;
    cy_q[0] <= '0;
    ax_q[0] <= req_i.axis_x;
    ay_q[0] <= req_i.axis_y;
    az_q[0] <= req_i.axis_z;
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (!z_q[i][ZW-1]) begin
        cx_q[i+1] <= cx_q[i] - dx;
        cy_q[i+1] <= cy_q[i] + dy;
        z_q[i+1]  <= z_q[i] - atan_entry(i);
      end else begin
        cx_q[i+1] <= cx_q[i] + dx;
        cy_q[i+1] <= cy_q[i] - dy;
        z_q[i+1]  <= z_q[i] + atan_entry(i);
      end
      ax_q[i+1] <= ax_q[i];
      ay_q[i+1] <= ay_q[i];
      az_q[i+1] <= az_q[i];
    end
  end

  // Quaternion in Q24
  assign px = ax_q[CS] * cy_q[CS];
  assign py = ay_q[CS] * cy_q[CS];
  assign pz = az_q[CS] * cy_q[CS];

  always_ff @(posedge clk_i) begin
    qx_q <= QW'(px >>> (IN_BITS - 2 + QUAT_DROP));
    qy_q <= QW'(py >>> (IN_BITS - 2 + QUAT_DROP));
    qz_q <= QW'(pz >>> (IN_BITS - 2 + QUAT_DROP));
    qw_q <= QW'(cx_q[CS] >>> QUAT_DROP);
  end

  always_ff @(posedge clk_i) begin
    xx_q <= qx_q * qx_q;
    yy_q <= qy_q * qy_q;
    zz_q <= qz_q * qz_q;
    ww_q <= qw_q * qw_q;
    xy_q <= qx_q * qy_q;
    xz_q <= qx_q * qz_q;
    yz_q <= qy_q * qz_q;
    xw_q <= qx_q * qw_q;
    yw_q <= qy_q * qw_q;
    zw_q <= qz_q * qw_q;
  end

  always_comb begin
    n2   = $unsigned(xx_q) + $unsigned(yy_q) + $unsigned(zz_q) + $unsigned(ww_q);
    t[0] = SW'(yy_q) + SW'(zz_q);
    t[1] = SW'(xy_q) + SW'(zw_q);
    t[2] = SW'(xz_q) - SW'(yw_q);
    t[3] = SW'(xy_q) - SW'(zw_q);
    t[4] = SW'(xx_q) + SW'(zz_q);
    t[5] = SW'(yz_q) + SW'(xw_q);
    t[6] = SW'(xz_q) + SW'(yw_q);
    t[7] = SW'(yz_q) - SW'(xw_q);
    t[8] = SW'(xx_q) + SW'(yy_q);
    for (int e = 0; e < 9; e++) begin
      mag[e] = t[e][SW-1] ? $unsigned(-t[e]) : $unsigned(t[e]);
    end
  end

  // Divider compares against four times the norm so the integer bits
  // come out of the same step as the fraction bits
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 9; e++) begin
      rem_q[0][e] <= RW'(mag[e]) << 1;
      quo_q[0][e] <= '0;
      neg_q[0][e] <= t[e][SW-1];
    end
    den_q[0] <= RW'(n2) << 2;
    dg_q[0]  <= (n2 == '0);
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] sh [9];
    logic [8:0]    ge;
    always_comb begin
      for (int e = 0; e < 9; e++) begin
        sh[e] = rem_q[k][e] << 1;
        ge[e] = (sh[e] >= den_q[k]);
      end
    end
    always_ff @(posedge clk_i) begin
      for (int e = 0; e < 9; e++) begin
        rem_q[k+1][e] <= ge[e] ? (sh[e] - den_q[k]) : sh[e];
        quo_q[k+1][e] <= {quo_q[k][e][QB-2:0], ge[e]};
      end
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      dg_q[k+1]  <= dg_q[k];
    end
  end

  // Round half up, then form diagonal or signed off-diagonal entry
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      rnd[e] = (QB + 1)'(quo_q[QB][e]) + (QB + 1)'(1);
      if (e % 4 == 0) begin
        ent[e] = ONE_EXT - signed'(EW'(rnd[e][QB:1]));
      end else if (neg_q[QB][e]) begin
        ent[e] = -signed'(EW'(rnd[e][QB:1]));
      end else begin
        ent[e] = signed'(EW'(rnd[e][QB:1]));
      end
      if (dg_q[QB]) begin
        ent_sat[e] = (e % 4 == 0) ? ONE_OUT : '0;
      end else if (ent[e] > ONE_EXT) begin
        ent_sat[e] = ONE_OUT;
      end else if (ent[e] < -ONE_EXT) begin
        ent_sat[e] = -ONE_OUT;
      end else begin
        ent_sat[e] = OUT_BITS'(ent[e]);
      end
    end
    res_d.m00 = ent_sat[0];
    res_d.m01 = ent_sat[1];
    res_d.m02 = ent_sat[2];
    res_d.m10 = ent_sat[3];
    res_d.m11 = ent_sat[4];
    res_d.m12 = ent_sat[5];
    res_d.m20 = ent_sat[6];
    res_d.m21 = ent_sat[7];
    res_d.m22 = ent_sat[8];
    res_d.degenerate = dg_q[QB];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT valid_o)
    else $error("request did not produce a result after the pipeline latency");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.m00 <= ONE_OUT) && (res_o.m00 >= -ONE_OUT) &&
                (res_o.m12 <= ONE_OUT) && (res_o.m12 >= -ONE_OUT) &&
                (res_o.m22 <= ONE_OUT) && (res_o.m22 >= -ONE_OUT))
    else $error("matrix entry outside [-1, 1]");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.degenerate |-> (res_o.m00 == ONE_OUT) && (res_o.m11 == ONE_OUT) &&
                                    (res_o.m22 == ONE_OUT) && (res_o.m01 == '0) &&
                                    (res_o.m21 == '0))
    else $error("zero norm result is not the identity");

endmodule
